FILE: src/sorted_name_list_navigator_top_macros.svh
// Assertion macros shared by the navigator RTL.
// No dependencies; included inside module bodies.
`ifndef SORTED_NAME_LIST_NAVIGATOR_TOP_MACROS_SVH
`define SORTED_NAME_LIST_NAVIGATOR_TOP_MACROS_SVH
// same-cycle implication
`define SNL_ASSERT_IMPL(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("implication check failed");
// next-cycle implication
`define SNL_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("next-cycle check failed");
`endif

FILE: src/snl_pkg.sv
// Package for the sorted name list navigator: op codes, state encoding and byte folding.
// No dependencies.
package snl_pkg;
   localparam logic [2:0] OP_CLEAR  = 3'd0;
   localparam logic [2:0] OP_APPEND = 3'd1;
   localparam logic [2:0] OP_COMMIT = 3'd2;
   localparam logic [2:0] OP_READ   = 3'd3;
   localparam logic [2:0] OP_STEP   = 3'd4;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_CMP_RD = 9'b000000010,
      ST_CMP_EV = 9'b000000100,
      ST_SH_RD  = 9'b000001000,
      ST_SH_WR  = 9'b000010000,
      ST_INS_RD = 9'b000100000,
      ST_INS_WR = 9'b001000000,
      ST_RD_WT  = 9'b010000000,
      ST_STEP   = 9'b100000000
   } state_type;

   // fold ASCII upper case to lower case
   function automatic logic [7:0] fold(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) return c + 8'd32;
      return c;
   endfunction
endpackage

FILE: src/snl_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module snl_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and read; the read data is registered
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

FILE: src/sorted_name_list_navigator_top.sv
// Top level of the sorted name list navigator: control sequencer and memories.
// Depends on snl_pkg, snl_ram and the macro header.
//
// Usage: an op is taken when start is high and busy is low; its result shows on
// the rsp_ ports for one cycle with rsp_valid and cannot be stalled, so the
// receiver must capture it then. Clear, append, out-of-range reads, refused
// commits and unused op codes answer straight from idle; a read waits on the
// registered RAM read. A step wraps the index by the count one wrap at a time.
// A commit walks the name store, whose single read port paces it: a read and a
// compare per byte while scanning rows, a read and a write per byte for each row
// shifted up, then a read and a write per byte to write the name.
module sorted_name_list_navigator_top #(
   parameter int MAX_NAMES  = 256,
   parameter int NAME_BYTES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [2:0]        req_op,
   input  logic [7:0]        req_char_in,
   input  logic [7:0]        req_rank,
   input  logic [5:0]        req_position,
   input  logic signed [8:0] req_delta,
   output logic              rsp_valid,
   output logic [7:0]        rsp_char_out,
   output logic [7:0]        rsp_rank_out,
   output logic [8:0]        rsp_count,
   output logic              rsp_dropped,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [8:0]        csr_wdata
);
   import snl_pkg::*;
   `include "sorted_name_list_navigator_top_macros.svh"

   localparam int BW = $clog2(NAME_BYTES);
   localparam int RW = $clog2(MAX_NAMES);
   localparam int CW = $clog2(MAX_NAMES + 1);
   localparam int AW = RW + BW;
   localparam int NW = ((RW > 9) ? RW : 9) + 2;
   localparam logic [BW-1:0] LAST_BYTE = BW'(NAME_BYTES - 1);

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [RW-1:0] cur_ff, cur_in;
   logic [BW-1:0] plen_ff, plen_in;
   logic [8:0]    max_ff;
   logic [RW-1:0] j_ff, j_in, k_ff, k_in;
   logic [BW-1:0] i_ff, i_in;
   logic signed [NW-1:0] n_ff, n_in, cnt_s;
   logic          rv_ff, rv_in, drop_ff, drop_in;
   logic [7:0]    ch_ff, ch_in, rk_ff, rk_in;

   logic          nm_we, pd_we;
   logic [AW-1:0] nm_wa, nm_ra;
   logic [7:0]    nm_wd, nm_rd, pd_rd;
   logic [BW-1:0] pd_ra;
   logic [7:0]    key_b, row_b;
   logic          full;

   snl_ram #(.DEPTH(MAX_NAMES * (2 ** BW)), .WIDTH(8)) u_names (
      .clock(clock), .wr_en(nm_we), .wr_addr(nm_wa), .wr_data(nm_wd),
      .rd_addr(nm_ra), .rd_data(nm_rd));

   snl_ram #(.DEPTH(2 ** BW), .WIDTH(8)) u_pending (
      .clock(clock), .wr_en(pd_we), .wr_addr(plen_ff), .wr_data(req_char_in),
      .rd_addr(pd_ra), .rd_data(pd_rd));

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign full      = (32'(count_ff) >= 32'(max_ff)) || (32'(count_ff) >= MAX_NAMES);
   assign cnt_s     = NW'(signed'({1'b0, count_ff}));
   assign key_b     = (i_ff < plen_ff) ? pd_rd : 8'd0;
   assign row_b     = fold(nm_rd);

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cur_in   = cur_ff;
      plen_in  = plen_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      i_in     = i_ff;
      n_in     = n_ff;
      rv_in    = 1'b0;
      drop_in  = drop_ff;
      ch_in    = ch_ff;
      rk_in    = rk_ff;
      nm_we    = 1'b0;
      nm_wa    = {j_ff, i_ff};
      nm_wd    = key_b;
      nm_ra    = {j_ff, i_ff};
      pd_we    = 1'b0;
      pd_ra    = i_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               drop_in = 1'b0;
               ch_in   = 8'd0;
               rk_in   = 8'd0;
               i_in    = '0;
               j_in    = '0;
               case (req_op)
                  OP_CLEAR: begin
                     count_in = '0;
                     cur_in   = '0;
                     rv_in    = 1'b1;
                  end
                  OP_APPEND: begin
                     if (req_char_in != 8'd0 && plen_ff < LAST_BYTE) begin
                        pd_we   = 1'b1;
                        plen_in = plen_ff + 1'b1;
                     end
                     rv_in = 1'b1;
                  end
                  OP_COMMIT: begin
                     if (full) begin
                        drop_in = 1'b1;
                        plen_in = '0;
                        rv_in   = 1'b1;
                     end else if (count_ff == '0) begin
                        state_in = ST_INS_RD;
                     end else begin
                        state_in = ST_CMP_RD;
                     end
                  end
                  OP_READ: begin
                     if (32'(req_rank) < 32'(count_ff) && 32'(req_position) < NAME_BYTES) begin
                        nm_ra    = {RW'(req_rank), BW'(req_position)};
                        state_in = ST_RD_WT;
                     end else begin
                        rv_in = 1'b1;
                     end
                  end
                  OP_STEP: begin
                     if (count_ff == '0) begin
                        drop_in = 1'b1;
                        rv_in   = 1'b1;
                     end else begin
                        n_in     = NW'(signed'({1'b0, cur_ff})) + NW'(req_delta);
                        state_in = ST_STEP;
                     end
                  end
                  default: rv_in = 1'b1;
               endcase
            end
         end
         ST_CMP_RD: state_in = ST_CMP_EV;
         ST_CMP_EV: begin
            if (row_b > fold(key_b)) begin
               // insertion point found: shift rows above it
               k_in     = RW'(count_ff);
               i_in     = '0;
               state_in = ST_SH_RD;
            end else if (row_b < fold(key_b) || row_b == 8'd0 || i_ff == LAST_BYTE) begin
               // row sorts at or below the key: next row
               i_in = '0;
               if (32'(j_ff) + 1 == 32'(count_ff)) begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_INS_RD;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_CMP_RD;
               end
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_CMP_RD;
            end
         end
         ST_SH_RD: begin
            nm_ra    = {k_ff - 1'b1, i_ff};
            state_in = ST_SH_WR;
         end
         ST_SH_WR: begin
            nm_we = 1'b1;
            nm_wa = {k_ff, i_ff};
            nm_wd = nm_rd;
            if (i_ff == LAST_BYTE) begin
               i_in = '0;
               k_in = k_ff - 1'b1;
               state_in = (k_ff - 1'b1 == j_ff) ? ST_INS_RD : ST_SH_RD;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SH_RD;
            end
         end
         ST_INS_RD: state_in = ST_INS_WR;
         ST_INS_WR: begin
            nm_we = 1'b1;
            if (i_ff == LAST_BYTE) begin
               count_in = count_ff + 1'b1;
               plen_in  = '0;
               rk_in    = 8'(j_ff);
               rv_in    = 1'b1;
               state_in = ST_IDLE;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_INS_RD;
            end
         end
         ST_RD_WT: begin
            ch_in    = nm_rd;
            rv_in    = 1'b1;
            state_in = ST_IDLE;
         end
         ST_STEP: begin
            // wrap by the count one step a cycle
            if (n_ff < 0) begin
               n_in = n_ff + cnt_s;
            end else if (n_ff >= cnt_s) begin
               n_in = n_ff - cnt_s;
            end else begin
               cur_in   = RW'(n_ff);
               rk_in    = 8'(n_ff);
               rv_in    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         cur_ff   <= '0;
         plen_ff  <= '0;
         max_ff   <= 9'd256;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cur_ff   <= cur_in;
         plen_ff  <= plen_in;
         rv_ff    <= rv_in;
         if (csr_valid && csr_ready) max_ff <= csr_wdata;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      j_ff    <= j_in;
      k_ff    <= k_in;
      i_ff    <= i_in;
      n_ff    <= n_in;
      drop_ff <= drop_in;
      ch_ff   <= ch_in;
      rk_ff   <= rk_in;
   end

   assign rsp_valid    = rv_ff;
   assign rsp_char_out = ch_ff;
   assign rsp_rank_out = rk_ff;
   assign rsp_count    = 9'(count_ff);
   assign rsp_dropped  = drop_ff;

   `SNL_ASSERT_IMPL(a_count_max, clock, reset, 1'b1, 32'(count_ff) <= MAX_NAMES)
   `SNL_ASSERT_NEXT(a_full_drop, clock, reset, start && !busy && req_op == OP_COMMIT && full, rsp_valid && rsp_dropped)
   `SNL_ASSERT_IMPL(a_shift_above, clock, reset, state_ff == ST_SH_RD, k_ff > j_ff)
endmodule

FILE: test/sorted_name_list_navigator_checker.sv
// Checker for the sorted name list navigator: watches the op, result and csr channels,
// predicts each result and compares it field by field. Depends on snl_pkg for op codes.
module sorted_name_list_navigator_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [2:0]        req_op,
   input  logic [7:0]        req_char_in,
   input  logic [7:0]        req_rank,
   input  logic [5:0]        req_position,
   input  logic signed [8:0] req_delta,
   input  logic              rsp_valid,
   input  logic [7:0]        rsp_char_out,
   input  logic [7:0]        rsp_rank_out,
   input  logic [8:0]        rsp_count,
   input  logic              rsp_dropped,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [8:0]        csr_wdata,
   output int                fail_count,
   output int                outstanding,
   output int                result_total
);
   timeunit 1ns;
   timeprecision 1ps;
   import snl_pkg::*;

   localparam int ROWS  = 256;
   localparam int BYTES = 64;

   typedef struct packed {
      logic [7:0] char_out;
      logic [7:0] rank_out;
      logic [8:0] count;
      logic       dropped;
   } outcome_type;

   outcome_type outcome_q[$];
   logic [7:0] rows [ROWS][BYTES];
   logic [7:0] draft [BYTES];
   logic [7:0] key [BYTES];
   int         draft_len;
   int         names_held;
   int         cursor;
   int         entry_limit;

   assign outstanding = outcome_q.size();

   function automatic logic [7:0] lower_byte(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   // order of stored row r against the key: -1 below, 0 equal, 1 above
   function automatic int order_vs_key(input int r);
      logic [7:0] x, y;
      for (int i = 0; i < BYTES; i++) begin
         x = lower_byte(rows[r][i]);
         y = lower_byte(key[i]);
         if (x != y) return (x < y) ? -1 : 1;
         if (x == 8'd0) return 0;
      end
      return 0;
   endfunction

   // advance the predicted state by one op and return its result
   function automatic outcome_type predict_outcome(input logic [2:0] op, input logic [7:0] ch,
                                                   input logic [7:0] rk, input logic [5:0] pos,
                                                   input logic signed [8:0] dl);
      outcome_type o;
      int       slot;
      int       lim;
      int       n;
      o = '0;
      case (op)
         OP_CLEAR: begin
            names_held = 0;
            cursor = 0;
         end
         OP_APPEND: begin
            if (ch != 8'd0 && draft_len < BYTES - 1) begin
               draft[draft_len] = ch;
               draft_len++;
            end
         end
         OP_COMMIT: begin
            lim = (entry_limit < ROWS) ? entry_limit : ROWS;
            for (int i = 0; i < BYTES; i++) key[i] = (i < draft_len) ? draft[i] : 8'd0;
            draft_len = 0;
            if (names_held >= lim) begin
               o.dropped = 1'b1;
            end else begin
               slot = 0;
               while (slot < names_held && order_vs_key(slot) <= 0) slot++;
               for (int k = names_held; k > slot; k--)
                  for (int i = 0; i < BYTES; i++) rows[k][i] = rows[k-1][i];
               for (int i = 0; i < BYTES; i++) rows[slot][i] = key[i];
               names_held++;
               o.rank_out = slot[7:0];
            end
         end
         OP_READ: begin
            if (rk < names_held) o.char_out = rows[rk][pos];
         end
         OP_STEP: begin
            if (names_held == 0) begin
               o.dropped = 1'b1;
            end else begin
               n = cursor + int'(dl);
               while (n < 0) n += names_held;
               cursor = n % names_held;
               o.rank_out = cursor[7:0];
            end
         end
         default: ;
      endcase
      o.count = names_held[8:0];
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         outcome_q.delete();
         draft_len   = 0;
         names_held  = 0;
         cursor      = 0;
         entry_limit = 256;
         fail_count  = 0;
         result_total = 0;
      end else begin
         // compare the result on the wire before queuing this edge's op
         if (rsp_valid) begin
            result_total++;
            if (outcome_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result char=%0h rank=%0d count=%0d dropped=%0b",
                        $time, rsp_char_out, rsp_rank_out, rsp_count, rsp_dropped);
            end else begin
               want = outcome_q.pop_front();
               if (rsp_char_out !== want.char_out || rsp_rank_out !== want.rank_out ||
                   rsp_count !== want.count || rsp_dropped !== want.dropped) begin
                  fail_count++;
                  $display("%0t: mismatch expected char=%0h rank=%0d count=%0d dropped=%0b",
                           $time, want.char_out, want.rank_out, want.count, want.dropped);
                  $display("%0t:          actual   char=%0h rank=%0d count=%0d dropped=%0b",
                           $time, rsp_char_out, rsp_rank_out, rsp_count, rsp_dropped);
               end
            end
         end
         if (start && !busy)
            outcome_q.push_back(predict_outcome(req_op, req_char_in, req_rank,
                                                req_position, req_delta));
         if (csr_valid && csr_ready) entry_limit = int'(csr_wdata);
      end
   end
endmodule

FILE: test/sorted_name_list_navigator_top_tb.sv
// Testbench top for the sorted name list navigator: clock, reset, op and csr stimulus,
// watchdog and verdict. Depends on snl_pkg, the navigator RTL and the checker module.
module sorted_name_list_navigator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import snl_pkg::*;

   localparam int IDLE_LIMIT = 300000;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [2:0]        req_op;
   logic [7:0]        req_char_in;
   logic [7:0]        req_rank;
   logic [5:0]        req_position;
   logic signed [8:0] req_delta;
   logic              rsp_valid;
   logic [7:0]        rsp_char_out;
   logic [7:0]        rsp_rank_out;
   logic [8:0]        rsp_count;
   logic              rsp_dropped;
   logic              csr_valid;
   logic              csr_ready;
   logic [8:0]        csr_wdata;
   int                fail_count;
   int                outstanding;
   int                result_total;
   int                quiet_cycles;
   int                ops_sent;
   int                max_gap;
   int                names_since_clear;

   sorted_name_list_navigator_top u_top (
      .clock, .reset, .start, .busy, .req_op, .req_char_in, .req_rank, .req_position,
      .req_delta, .rsp_valid, .rsp_char_out, .rsp_rank_out, .rsp_count, .rsp_dropped,
      .csr_valid, .csr_ready, .csr_wdata
   );

   sorted_name_list_navigator_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // end the run when nothing transfers for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("== FAIL ==");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // drive one op at the falling edge and hold it until the block takes it
   task automatic issue(input logic [2:0] op, input logic [7:0] ch = 8'd0,
                        input logic [7:0] rk = 8'd0, input logic [5:0] pos = 6'd0,
                        input logic signed [8:0] dl = 9'sd0);
      int gap;
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_op = op;
      req_char_in = ch;
      req_rank = rk;
      req_position = pos;
      req_delta = dl;
      start = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      ops_sent++;
      if (op == OP_CLEAR) names_since_clear = 0;
      if (op == OP_COMMIT) names_since_clear++;
   endtask

   // hold off until every result is back and the block is idle
   task automatic drain();
      start = 1'b0;
      while (outstanding != 0 || busy) @(negedge clock);
   endtask

   task automatic write_limit(input logic [8:0] value);
      drain();
      csr_wdata = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic add_name(input string s);
      foreach (s[i]) issue(OP_APPEND, s[i]);
      issue(OP_COMMIT);
   endtask

   function automatic logic [7:0] name_byte();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) return 8'(8'h41 + $urandom_range(0, 25));
      if (pick < 7) return 8'(8'h61 + $urandom_range(0, 25));
      if (pick < 8) return 8'(8'h30 + $urandom_range(0, 9));
      return 8'($urandom_range(0, 255));
   endfunction

   // mostly well-formed names with random content, plus reads, steps and noise
   task automatic random_phase(input int budget);
      int stop_at;
      int pick;
      int len;
      stop_at = ops_sent + budget;
      while (ops_sent < stop_at) begin
         max_gap = ($urandom_range(0, 3) == 0) ? 0 : 18;
         pick = $urandom_range(0, 99);
         if (names_since_clear >= 12 && pick < 30) begin
            issue(OP_CLEAR);
         end else if (pick < 45) begin
            len = ($urandom_range(0, 40) == 0) ? $urandom_range(60, 68) : $urandom_range(0, 6);
            repeat (len) issue(OP_APPEND, name_byte());
            issue(OP_COMMIT);
         end else if (pick < 75) begin
            issue(OP_READ, 8'($urandom_range(0, 255)),
                  8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, names_since_clear)),
                  6'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                 : $urandom_range(0, 7)));
         end else if (pick < 90) begin
            issue(OP_STEP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  6'($urandom_range(0, 63)), 9'(int'($urandom_range(0, 510)) - 255));
         end else if (pick < 95) begin
            issue(3'($urandom_range(5, 7)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                  9'(int'($urandom_range(0, 510)) - 255));
         end else begin
            issue(OP_APPEND, 8'd0);
            if (pick == 99) drain();
         end
      end
   endtask

   initial begin
      int limits [6] = '{256, 0, 3, 1, 20, 256};
      reset = 1'b1;
      start = 1'b0;
      req_op = OP_CLEAR;
      req_char_in = 8'd0;
      req_rank = 8'd0;
      req_position = 6'd0;
      req_delta = 9'sd0;
      csr_valid = 1'b0;
      csr_wdata = 9'd0;
      ops_sent = 0;
      max_gap = 0;
      names_since_clear = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty list, unused ops, ignored bytes, ordering ties and prefixes
      write_limit(9'd256);
      issue(OP_STEP, 8'd0, 8'd0, 6'd0, 9'sd1);
      issue(OP_READ, 8'd0, 8'd0, 6'd0);
      issue(3'd5);
      issue(3'd6);
      issue(3'd7, 8'hFF, 8'hFF, 6'h3F, -9'sd255);
      issue(OP_APPEND, 8'd0);
      add_name("Ab");
      add_name("ab");
      add_name("a");
      issue(OP_APPEND, 8'hFF);
      issue(OP_APPEND, "Z");
      issue(OP_COMMIT);
      issue(OP_COMMIT);
      issue(OP_READ, 8'd0, 8'd4, 6'd0);
      issue(OP_READ, 8'd0, 8'd255, 6'd63);
      issue(OP_READ, 8'd0, 8'd1, 6'd63);
      issue(OP_STEP, 8'd0, 8'd0, 6'd0, -9'sd255);
      issue(OP_STEP, 8'd0, 8'd0, 6'd0, 9'sd255);
      issue(OP_CLEAR);

      // random phases over several list limits, idle between writes
      foreach (limits[p]) begin
         write_limit(9'(limits[p]));
         random_phase(70);
      end

      drain();
      repeat (20) @(posedge clock);
      $display("sent %0d ops and checked %0d results over list limits 0, 1, 3, 20 and 256",
                ops_sent, result_total);
      $display("covered ties, prefixes, truncation, full list, wrapping steps and unused ops");
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
